@@ src/nps_pkg.sv @@
// Shared definitions for the 2-D nearest point search block.
// Holds default parameters, the item command codes and the control/status structs.
// Depends on nothing else.
package nps_pkg;

    localparam int DEF_MAX_POINTS = 1024;
    localparam int DEF_COORD_BITS = 16;
    localparam int OUT_IDX_W      = 10;
    localparam int CMD_W          = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef struct packed {
        logic load;
        logic clear;
        logic start;
        logic publish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic scan_done;
    } t_dp_status;

    function automatic int nps_addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

@@ src/nps_ram.sv @@
// Generic single write port, single read port RAM with a registered read.
// Used for the reference point store. Depends on nothing else.
module nps_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/nps_ctrl.sv @@
// Controller state machine for the nearest point search block.
// Decodes accepted items, sequences a query scan and owns the result valid flag.
// Depends on nps_pkg.
module nps_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_cmd,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output nps_pkg::t_ctrl_cmd o_cmd,
    input  nps_pkg::t_dp_status i_status
);
    import nps_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (t_cmd'(i_cmd))
                        CMD_LOAD:  o_cmd.load  = 1'b1;
                        CMD_CLEAR: o_cmd.clear = 1'b1;
                        CMD_QUERY: begin
                            o_cmd.start = 1'b1;
                            n_state     = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ src/nps_datapath.sv @@
// Datapath of the nearest point search block: point store, point count and the
// pipelined distance and minimum tracking scan. Depends on nps_pkg and nps_ram.
module nps_datapath #(
    parameter int MAX_POINTS = nps_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = nps_pkg::DEF_COORD_BITS,
    parameter int ADDR_W     = nps_pkg::nps_addr_w(MAX_POINTS),
    parameter int CNT_W      = $clog2(MAX_POINTS + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nps_pkg::t_ctrl_cmd            i_cmd,
    output nps_pkg::t_dp_status           o_status,
    input  logic signed [COORD_BITS-1:0]  i_coord_x,
    input  logic signed [COORD_BITS-1:0]  i_coord_y,
    output logic [nps_pkg::OUT_IDX_W-1:0] o_nearest_index,
    output logic                          o_store_empty
);
    import nps_pkg::*;

    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int SUM_W = SQ_W + 1;

    logic [CNT_W-1:0]             r_count;
    logic signed [COORD_BITS-1:0] r_qx, r_qy;
    logic                         r_issuing;
    logic [CNT_W-1:0]             r_issue_idx;
    logic [CNT_W-1:0]             w_issue_next;
    logic [3:0]                   r_vld;
    logic [ADDR_W-1:0]            r_idx [4];
    logic [2*COORD_BITS-1:0]      w_rdata;
    logic signed [COORD_BITS-1:0] w_rx, w_ry;
    logic signed [COORD_BITS:0]   r_dx, r_dy;
    logic signed [2*COORD_BITS+1:0] w_px, w_py;
    logic [SQ_W-1:0]              r_sqx, r_sqy;
    logic [SUM_W-1:0]             r_sum;
    logic [SUM_W-1:0]             r_best_d;
    logic [ADDR_W-1:0]            r_best_idx;
    logic                         r_have;
    logic [ADDR_W+OUT_IDX_W-1:0]  w_idx_ext;
    logic [OUT_IDX_W-1:0]         r_out_idx;
    logic                         r_out_empty;
    logic                         w_we;

    assign w_we         = i_cmd.load && (r_count != CNT_W'(MAX_POINTS));
    assign w_issue_next = r_issue_idx + CNT_W'(1);

    nps_ram #(
        .WIDTH  (2 * COORD_BITS),
        .DEPTH  (MAX_POINTS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata ({i_coord_x, i_coord_y}),
        .i_re    (r_issuing),
        .i_raddr (r_issue_idx[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_rx = w_rdata[2*COORD_BITS-1:COORD_BITS];
    assign w_ry = w_rdata[COORD_BITS-1:0];
    assign w_px = r_dx * r_dx;
    assign w_py = r_dy * r_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_issuing <= 1'b0;
            r_vld     <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (w_we) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.start) begin
                r_issuing <= (r_count != '0);
            end else if (r_issuing && (w_issue_next == r_count)) begin
                r_issuing <= 1'b0;
            end
            r_vld <= {r_vld[2:0], r_issuing};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_qx        <= i_coord_x;
            r_qy        <= i_coord_y;
            r_issue_idx <= '0;
            r_have      <= 1'b0;
            r_best_idx  <= '0;
        end else begin
            if (r_issuing) begin
                r_issue_idx <= w_issue_next;
            end
            if (r_vld[3] && (!r_have || (r_sum < r_best_d))) begin
                r_have     <= 1'b1;
                r_best_d   <= r_sum;
                r_best_idx <= r_idx[3];
            end
        end
        r_idx[0] <= r_issue_idx[ADDR_W-1:0];
        r_idx[1] <= r_idx[0];
        r_idx[2] <= r_idx[1];
        r_idx[3] <= r_idx[2];
        r_dx     <= {r_qx[COORD_BITS-1], r_qx} - {w_rx[COORD_BITS-1], w_rx};
        r_dy     <= {r_qy[COORD_BITS-1], r_qy} - {w_ry[COORD_BITS-1], w_ry};
        r_sqx    <= w_px[SQ_W-1:0];
        r_sqy    <= w_py[SQ_W-1:0];
        r_sum    <= {1'b0, r_sqx} + {1'b0, r_sqy};
        if (i_cmd.publish) begin
            r_out_idx   <= w_idx_ext[OUT_IDX_W-1:0];
            r_out_empty <= !r_have;
        end
    end

    assign w_idx_ext          = {{OUT_IDX_W{1'b0}}, r_best_idx};
    assign o_status.scan_done = !r_issuing && (r_vld == '0);
    assign o_nearest_index    = r_out_idx;
    assign o_store_empty      = r_out_empty;

endmodule

@@ src/nearest_point_search_2d.sv @@
// Top level of the 2-D nearest point search block; depends on nps_pkg, nps_ctrl, nps_datapath.
// A load or clear item keeps the input ready; the next item is accepted in the following cycle.
// A query reads the stored points from RAM, one per cycle, into a distance and minimum pipeline
// (difference, square, sum, minimum compare) before its result is registered; the next item
// is accepted in the cycle after that, and an untaken earlier result delays the query's result.
// Synchronous active-low reset empties the store and drops any pending result; no RAM clearing.
module nearest_point_search_2d #(
    parameter int MAX_POINTS = nps_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = nps_pkg::DEF_COORD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [nps_pkg::CMD_W-1:0]     i_cmd,
    input  logic signed [COORD_BITS-1:0]  i_coord_x,
    input  logic signed [COORD_BITS-1:0]  i_coord_y,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [nps_pkg::OUT_IDX_W-1:0] o_nearest_index,
    output logic                          o_store_empty
);
    import nps_pkg::*;

    localparam int ADDR_W = nps_addr_w(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    nps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    nps_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS),
        .ADDR_W     (ADDR_W),
        .CNT_W      (CNT_W)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_coord_x       (i_coord_x),
        .i_coord_y       (i_coord_y),
        .o_nearest_index (o_nearest_index),
        .o_store_empty   (o_store_empty)
    );

    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.publish |-> (!o_out_valid || i_out_ready))
        else $error("Result published over an untaken result.");

    a_publish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.publish |=> o_out_valid)
        else $error("Published result is not presented.");

    a_scan_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.start |=> !o_in_ready)
        else $error("Input accepted during a query scan.");

    a_empty_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_store_empty) |-> (o_nearest_index == '0))
        else $error("Empty store result carries a nonzero index.");

endmodule
